/* rtl/tgp_pkg.sv */
// ----------------------------------------------------------------------------
// tgp_pkg
// Shared types, codes and the control store of the turtle grid plotter.
// ----------------------------------------------------------------------------
package tgp_pkg;

  localparam int GRID_DEF  = 32;
  localparam int PRINT_MAX = 32;
  localparam int CNT_W     = 8;
  localparam int POS_EXT_W = 10;

  // command codes
  localparam logic [2:0] FN_MOVE     = 3'd0;
  localparam logic [2:0] FN_PEN_UP   = 3'd1;
  localparam logic [2:0] FN_PEN_DOWN = 3'd2;
  localparam logic [2:0] FN_TURN_R   = 3'd3;
  localparam logic [2:0] FN_TURN_L   = 3'd4;
  localparam logic [2:0] FN_PRINT    = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_OOR    = 2'd1;
  localparam logic [1:0] ST_HALTED = 2'd2;

  // heading codes
  localparam logic [1:0] HD_RIGHT = 2'd0;
  localparam logic [1:0] HD_DOWN  = 2'd1;
  localparam logic [1:0] HD_LEFT  = 2'd2;
  localparam logic [1:0] HD_UP    = 2'd3;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] distance;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  row_index;
    logic [31:0] row_bits;
    logic [4:0]  pos_row;
    logic [4:0]  pos_col;
    logic [1:0]  heading;
    logic        pen_down;
    logic        last;
  } result_t;

  typedef enum logic [3:0] {
    U_IDLE     = 4'd0,
    U_HALTED   = 4'd1,
    U_PEN_UP   = 4'd2,
    U_PEN_DOWN = 4'd3,
    U_TURN_R   = 4'd4,
    U_TURN_L   = 4'd5,
    U_NOP      = 4'd6,
    U_MV_CHK   = 4'd7,
    U_MV_INIT  = 4'd8,
    U_MV_RD    = 4'd9,
    U_MV_WB    = 4'd10,
    U_MV_FIN   = 4'd11,
    U_MV_OOR   = 4'd12,
    U_PR_INIT  = 4'd13,
    U_PR_RD    = 4'd14,
    U_PR_END   = 4'd15
  } ustep_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_EMIT_HALT,
    A_PEN_UP,
    A_PEN_DOWN,
    A_TURN_R,
    A_TURN_L,
    A_EMIT_OK,
    A_WALK_INIT,
    A_READ,
    A_MOVE_COMMIT,
    A_HALT,
    A_PRINT_INIT,
    A_PRINT_READ
  } uaction_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_DISPATCH,
    C_OOR,
    C_PENUP,
    C_MORE
  } ucond_t;

  typedef struct packed {
    uaction_t action;
    ucond_t   cond;
    ustep_t   target;
  } uword_t;

  typedef struct packed {
    logic oor;
    logic pen_up;
    logic more;
  } uflags_t;

  function automatic uword_t ucode_rom(input ustep_t addr);
    uword_t w;
    unique case (addr)
      U_IDLE:     w = '{A_NONE,        C_DISPATCH, U_IDLE};
      U_HALTED:   w = '{A_EMIT_HALT,   C_ALWAYS,   U_IDLE};
      U_PEN_UP:   w = '{A_PEN_UP,      C_ALWAYS,   U_IDLE};
      U_PEN_DOWN: w = '{A_PEN_DOWN,    C_ALWAYS,   U_IDLE};
      U_TURN_R:   w = '{A_TURN_R,      C_ALWAYS,   U_IDLE};
      U_TURN_L:   w = '{A_TURN_L,      C_ALWAYS,   U_IDLE};
      U_NOP:      w = '{A_EMIT_OK,     C_ALWAYS,   U_IDLE};
      U_MV_CHK:   w = '{A_NONE,        C_OOR,      U_MV_OOR};
      U_MV_INIT:  w = '{A_WALK_INIT,   C_PENUP,    U_MV_FIN};
      U_MV_RD:    w = '{A_READ,        C_MORE,     U_MV_RD};
      U_MV_WB:    w = '{A_NONE,        C_NEXT,     U_IDLE};
      U_MV_FIN:   w = '{A_MOVE_COMMIT, C_ALWAYS,   U_IDLE};
      U_MV_OOR:   w = '{A_HALT,        C_ALWAYS,   U_IDLE};
      U_PR_INIT:  w = '{A_PRINT_INIT,  C_NEXT,     U_IDLE};
      U_PR_RD:    w = '{A_PRINT_READ,  C_MORE,     U_PR_RD};
      U_PR_END:   w = '{A_NONE,        C_ALWAYS,   U_IDLE};
    endcase
    return w;
  endfunction

  function automatic ustep_t ucode_dispatch(input logic [2:0] func, input logic halted);
    ustep_t s;
    if (halted) begin
      s = U_HALTED;
    end else begin
      unique case (func)
        FN_MOVE:     s = U_MV_CHK;
        FN_PEN_UP:   s = U_PEN_UP;
        FN_PEN_DOWN: s = U_PEN_DOWN;
        FN_TURN_R:   s = U_TURN_R;
        FN_TURN_L:   s = U_TURN_L;
        FN_PRINT:    s = U_PR_INIT;
        default:     s = U_NOP;
      endcase
    end
    return s;
  endfunction

endpackage

/* rtl/tgp_grid.sv */
// ----------------------------------------------------------------------------
// tgp_grid
// Grid store: one row per word, registered read, per-row valid bits so that
// rows never written read as clear after reset.
// ----------------------------------------------------------------------------
module tgp_grid #(
  parameter int  GRID = tgp_pkg::GRID_DEF,
  localparam int AW   = $clog2(GRID)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output logic [GRID-1:0] rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [GRID-1:0] wr_data
);
  import tgp_pkg::*;

  logic [GRID-1:0] mem [GRID];
  logic [GRID-1:0] row_valid;
  logic [GRID-1:0] mem_q;
  logic            vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      vld_q     <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= row_valid[rd_addr];
      end
    end
  end

  // a row never written reads as clear
  assign rd_data = vld_q ? mem_q : '0;

endmodule

/* rtl/tgp_useq.sv */
// ----------------------------------------------------------------------------
// tgp_useq
// Microsequencer: step counter, control store lookup and jump logic.
// ----------------------------------------------------------------------------
module tgp_useq (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         func,
  input  logic               halted,
  input  tgp_pkg::uflags_t   flags,
  output tgp_pkg::uword_t    uw,
  output logic               busy
);
  import tgp_pkg::*;

  ustep_t upc;
  ustep_t upc_next;
  ustep_t upc_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // next step
  always_comb begin
    upc_inc = ustep_t'(upc + 4'd1);
    unique case (uw.cond)
      C_NEXT:     upc_next = upc_inc;
      C_ALWAYS:   upc_next = uw.target;
      C_DISPATCH: upc_next = start ? ucode_dispatch(func, halted) : U_IDLE;
      C_OOR:      upc_next = flags.oor ? uw.target : upc_inc;
      C_PENUP:    upc_next = flags.pen_up ? uw.target : upc_inc;
      C_MORE:     upc_next = flags.more ? uw.target : upc_inc;
      default:    upc_next = U_IDLE;
    endcase
  end

  // control word out
  always_comb begin
    uw   = ucode_rom(upc);
    busy = (upc != U_IDLE);
  end

endmodule

/* rtl/turtle_grid_plotter_top.sv */
// ----------------------------------------------------------------------------
// turtle_grid_plotter_top
// Turtle plotter on a GRID x GRID bit grid, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its results appear
// on res with res_valid high for one cycle each and must be captured then.
// Pen, turn and unused commands, and any command once halted, give a single
// result. A move with the pen down runs four steps plus one per covered row
// (one row for horizontal moves, up to GRID rows for vertical ones), since the
// grid store has one read and one write port and a vertical line touches one
// row per cycle; with the pen up a move runs three steps, and one that would
// leave the grid runs two. A print streams the first min(GRID,32) rows on
// consecutive cycles and holds busy through its init, read and end steps. The
// grid reads as clear after reset with no clearing pass.
// ----------------------------------------------------------------------------
module turtle_grid_plotter_top #(
  parameter int GRID = tgp_pkg::GRID_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tgp_pkg::cmd_t    cmd,
  output tgp_pkg::result_t res,
  output logic             res_valid
);
  import tgp_pkg::*;

  localparam int AW         = $clog2(GRID);
  localparam int PRINT_ROWS = (GRID > PRINT_MAX) ? PRINT_MAX : GRID;
  localparam int EW         = POS_EXT_W;

  uword_t  uw;
  uflags_t flags;

  cmd_t             cmd_q;
  logic [AW-1:0]    row, row_next;
  logic [AW-1:0]    col, col_next;
  logic [1:0]       heading, heading_next;
  logic             pen, pen_next;
  logic             halted, halted_next;
  logic [AW-1:0]    walk_row, walk_row_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [GRID-1:0]  mask, mask_next;
  logic             wr_pend;
  logic [AW-1:0]    wr_row;
  logic             prd_pend;
  logic [AW-1:0]    prd_row;
  logic             prd_last;
  result_t          res_next;
  logic             emit;
  logic [1:0]       emit_status;

  logic [CNT_W-1:0] steps;
  logic signed [EW-1:0] er_s, ec_s, rs, cs, st;
  logic             oor;
  logic             vertical;
  logic [AW-1:0]    er_u, ec_u, lo, hi;
  logic [GRID-1:0]  span_mask, dot_mask;

  logic             rd_en;
  logic [GRID-1:0]  rd_data;
  logic [63:0]      rd_wide;

  localparam logic [AW-1:0] COL_MAX = AW'(GRID - 1);

  tgp_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (cmd.func),
    .halted (halted),
    .flags  (flags),
    .uw     (uw),
    .busy   (busy)
  );

  tgp_grid #(.GRID(GRID)) u_grid (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (walk_row),
    .rd_data (rd_data),
    .wr_en   (wr_pend),
    .wr_addr (wr_row),
    .wr_data (rd_data | mask)
  );

  // end point of the move and range check
  always_comb begin
    steps = (cmd_q.distance == 8'd0) ? '0 : cmd_q.distance - 8'd1;
    rs    = signed'(EW'(row));
    cs    = signed'(EW'(col));
    st    = signed'(EW'(steps));
    er_s  = rs;
    ec_s  = cs;
    unique case (heading)
      HD_RIGHT: ec_s = cs + st;
      HD_DOWN:  er_s = rs + st;
      HD_LEFT:  ec_s = cs - st;
      HD_UP:    er_s = rs - st;
      default:  ;
    endcase
    oor = (er_s < 0) || (er_s > signed'(EW'(GRID - 1)))
       || (ec_s < 0) || (ec_s > signed'(EW'(GRID - 1)));
    er_u     = AW'(er_s);
    ec_u     = AW'(ec_s);
    vertical = (heading == HD_DOWN) || (heading == HD_UP);
    lo       = (ec_u < col) ? ec_u : col;
    hi       = (ec_u < col) ? col : ec_u;
    span_mask = ({GRID{1'b1}} << lo) & ({GRID{1'b1}} >> (COL_MAX - hi));
    dot_mask  = {{(GRID-1){1'b0}}, 1'b1} << col;
  end

  assign flags.oor    = oor;
  assign flags.pen_up = !pen;
  assign flags.more   = (cnt != '0);

  assign rd_en = (uw.action == A_READ) || (uw.action == A_PRINT_READ);

  // datapath actions
  always_comb begin
    row_next      = row;
    col_next      = col;
    heading_next  = heading;
    pen_next      = pen;
    halted_next   = halted;
    walk_row_next = walk_row;
    cnt_next      = cnt;
    mask_next     = mask;
    emit          = 1'b0;
    emit_status   = ST_OK;
    unique case (uw.action)
      A_NONE: ;
      A_EMIT_HALT: begin
        emit        = 1'b1;
        emit_status = ST_HALTED;
      end
      A_PEN_UP: begin
        pen_next = 1'b0;
        emit     = 1'b1;
      end
      A_PEN_DOWN: begin
        pen_next = 1'b1;
        emit     = 1'b1;
      end
      A_TURN_R: begin
        heading_next = heading + 2'd1;
        emit         = 1'b1;
      end
      A_TURN_L: begin
        heading_next = heading + 2'd3;
        emit         = 1'b1;
      end
      A_EMIT_OK: emit = 1'b1;
      A_WALK_INIT: begin
        walk_row_next = row;
        cnt_next      = vertical ? steps : '0;
        mask_next     = vertical ? dot_mask : span_mask;
      end
      A_READ: begin
        walk_row_next = (heading == HD_UP) ? walk_row - 1'b1 : walk_row + 1'b1;
        if (cnt != '0) begin
          cnt_next = cnt - 1'b1;
        end
      end
      A_MOVE_COMMIT: begin
        row_next = er_u;
        col_next = ec_u;
        emit     = 1'b1;
      end
      A_HALT: begin
        halted_next = 1'b1;
        emit        = 1'b1;
        emit_status = ST_OOR;
      end
      A_PRINT_INIT: begin
        walk_row_next = '0;
        cnt_next      = CNT_W'(PRINT_ROWS - 1);
      end
      A_PRINT_READ: begin
        walk_row_next = walk_row + 1'b1;
        if (cnt != '0) begin
          cnt_next = cnt - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result assembly
  always_comb begin
    rd_wide            = 64'(rd_data);
    res_next           = '0;
    res_next.pos_row   = 5'(row_next);
    res_next.pos_col   = 5'(col_next);
    res_next.heading   = heading_next;
    res_next.pen_down  = pen_next;
    res_next.last      = 1'b1;
    res_next.status    = emit_status;
    if (!emit && prd_pend) begin
      res_next.status    = ST_OK;
      res_next.row_index = 5'(prd_row);
      res_next.row_bits  = rd_wide[31:0];
      res_next.last      = prd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      col       <= '0;
      heading   <= HD_RIGHT;
      pen       <= 1'b0;
      halted    <= 1'b0;
      wr_pend   <= 1'b0;
      prd_pend  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      row       <= row_next;
      col       <= col_next;
      heading   <= heading_next;
      pen       <= pen_next;
      halted    <= halted_next;
      wr_pend   <= (uw.action == A_READ);
      prd_pend  <= (uw.action == A_PRINT_READ);
      res_valid <= emit || prd_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= cmd;
    end
    walk_row <= walk_row_next;
    cnt      <= cnt_next;
    mask     <= mask_next;
    wr_row   <= walk_row;
    prd_row  <= walk_row;
    prd_last <= (cnt == '0);
    res      <= res_next;
  end

  // write-back and print streaming never overlap
  a_pend_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({wr_pend, prd_pend}))
    else $error("write-back and print read pending together");

  // nothing left to write back once the sequencer is idle
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !wr_pend)
    else $error("grid write pending while idle");

  // an out-of-range result comes with the halt flag set
  a_oor_halts: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_OOR) |-> halted)
    else $error("out-of-range status without halt");

  // print rows stream on consecutive cycles until the last one
  a_print_burst: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.last) |=> res_valid)
    else $error("gap in print row stream");

endmodule

/* tb/sv/turtle_grid_plotter_top_test.sv */
// ----------------------------------------------------------------------------
// turtle_grid_plotter_top_test
// Self-checking bench for the turtle grid plotter.
// ----------------------------------------------------------------------------
// A driver feeds plotter commands from a queue in random bursts. A monitor
// predicts the grid, pen, heading and position for every accepted command
// and checks each result strobe against the oldest predicted result. The
// commands first walk the grid edges, then run random in-range walks, and
// finally leave the grid so that the halted behaviour is exercised.
// ----------------------------------------------------------------------------
module turtle_grid_plotter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tgp_pkg::*;

  localparam int         SIDE       = GRID_DEF;
  localparam int         PRINT_ROWS = (SIDE > PRINT_MAX) ? PRINT_MAX : SIDE;
  localparam logic [2:0] FN_SPARE_A = 3'd6;
  localparam logic [2:0] FN_SPARE_B = 3'd7;
  localparam int         RAND_CMDS  = 450;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  cmd_t    cmd = '0;
  result_t res;
  logic    res_valid;

  turtle_grid_plotter_top #(
    .GRID(SIDE)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .res      (res),
    .res_valid(res_valid)
  );

  cmd_t    cmd_queue[$];
  result_t predicted_res[$];
  int      mismatches = 0;
  logic    taken = 1'b0;
  int      burst_left = 0;
  int      gap_left = 0;

  // plotter state as seen by the predictor
  logic [31:0] plot_grid [SIDE];
  int          plot_row = 0;
  int          plot_col = 0;
  logic [1:0]  plot_heading = HD_RIGHT;
  logic        plot_pen = 1'b0;
  logic        plot_halted = 1'b0;

  // position and heading as tracked while the commands are generated
  int          walk_row = 0;
  int          walk_col = 0;
  logic [1:0]  walk_heading = HD_RIGHT;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    for (int r = 0; r < SIDE; r++) plot_grid[r] = '0;
  end

  function automatic int room_ahead();
    case (walk_heading)
      HD_RIGHT: return SIDE - walk_col;
      HD_DOWN:  return SIDE - walk_row;
      HD_LEFT:  return walk_col + 1;
      default:  return walk_row + 1;
    endcase
  endfunction

  task automatic queue_cmd(input logic [2:0] func, input logic [7:0] distance);
    cmd_t c;
    int   steps;
    c.func     = func;
    c.distance = distance;
    cmd_queue.push_back(c);
    steps = (distance == 0) ? 0 : int'(distance) - 1;
    case (func)
      FN_MOVE: begin
        case (walk_heading)
          HD_RIGHT: walk_col += steps;
          HD_DOWN:  walk_row += steps;
          HD_LEFT:  walk_col -= steps;
          default:  walk_row -= steps;
        endcase
      end
      FN_TURN_R: walk_heading = walk_heading + 2'd1;
      FN_TURN_L: walk_heading = walk_heading - 2'd1;
      default: ;
    endcase
  endtask

  task automatic plot_command(input cmd_t c);
    result_t r;
    int      steps, dr, dc, er, ec, i;
    r      = '0;
    r.last = 1'b1;
    if (plot_halted) begin
      r.status = ST_HALTED;
    end else begin
      case (c.func)
        FN_MOVE: begin
          steps = (c.distance == 0) ? 0 : int'(c.distance) - 1;
          dr = 0;
          dc = 0;
          case (plot_heading)
            HD_RIGHT: dc = 1;
            HD_DOWN:  dr = 1;
            HD_LEFT:  dc = -1;
            default:  dr = -1;
          endcase
          er = plot_row + dr * steps;
          ec = plot_col + dc * steps;
          if (er < 0 || er >= SIDE || ec < 0 || ec >= SIDE) begin
            plot_halted = 1'b1;
            r.status    = ST_OOR;
          end else begin
            if (plot_pen) begin
              for (i = 0; i <= steps; i++)
                plot_grid[plot_row + dr * i][plot_col + dc * i] = 1'b1;
            end
            plot_row = er;
            plot_col = ec;
          end
        end
        FN_PEN_UP:   plot_pen = 1'b0;
        FN_PEN_DOWN: plot_pen = 1'b1;
        FN_TURN_R:   plot_heading = plot_heading + 2'd1;
        FN_TURN_L:   plot_heading = plot_heading - 2'd1;
        FN_PRINT: begin
          r.pos_row  = 5'(plot_row);
          r.pos_col  = 5'(plot_col);
          r.heading  = plot_heading;
          r.pen_down = plot_pen;
          for (i = 0; i < PRINT_ROWS; i++) begin
            r.row_index = 5'(i);
            r.row_bits  = plot_grid[i];
            r.last      = (i == PRINT_ROWS - 1);
            predicted_res.push_back(r);
          end
          return;
        end
        default: ;
      endcase
    end
    r.pos_row  = 5'(plot_row);
    r.pos_col  = 5'(plot_col);
    r.heading  = plot_heading;
    r.pen_down = plot_pen;
    predicted_res.push_back(r);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (predicted_res.size() == 0) begin
      $error("result strobe with no transaction pending: %p", got);
      mismatches++;
      return;
    end
    want = predicted_res.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.row_index !== want.row_index) begin
      $error("row_index: expected %0d, got %0d", want.row_index, got.row_index);
      mismatches++;
    end
    if (got.row_bits !== want.row_bits) begin
      $error("row_bits: expected %h, got %h", want.row_bits, got.row_bits);
      mismatches++;
    end
    if (got.pos_row !== want.pos_row) begin
      $error("pos_row: expected %0d, got %0d", want.pos_row, got.pos_row);
      mismatches++;
    end
    if (got.pos_col !== want.pos_col) begin
      $error("pos_col: expected %0d, got %0d", want.pos_col, got.pos_col);
      mismatches++;
    end
    if (got.heading !== want.heading) begin
      $error("heading: expected %0d, got %0d", want.heading, got.heading);
      mismatches++;
    end
    if (got.pen_down !== want.pen_down) begin
      $error("pen_down: expected %0d, got %0d", want.pen_down, got.pen_down);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      mismatches++;
    end
  endtask

  // driver: hold each transaction until taken, then idle in random gaps
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (cmd_queue.size() > 0) begin
      cmd   <= cmd_queue.pop_front();
      start <= 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 30);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: predict on acceptance, check on every strobe
  always @(posedge clk) begin
    taken <= !rst && start && !busy;
    if (!rst) begin
      if (start && !busy) plot_command(cmd);
      if (res_valid) check_result(res);
    end
  end

  initial begin
    int pick;

    // edges of the grid, both pen states, every command
    queue_cmd(FN_PRINT, 8'd0);
    queue_cmd(FN_PEN_DOWN, 8'd0);
    queue_cmd(FN_MOVE, 8'd0);
    queue_cmd(FN_MOVE, 8'd32);
    queue_cmd(FN_TURN_R, 8'd0);
    queue_cmd(FN_MOVE, 8'd32);
    queue_cmd(FN_TURN_R, 8'd0);
    queue_cmd(FN_MOVE, 8'd1);
    queue_cmd(FN_PEN_UP, 8'd0);
    queue_cmd(FN_MOVE, 8'd16);
    queue_cmd(FN_TURN_R, 8'd0);
    queue_cmd(FN_PEN_DOWN, 8'd0);
    queue_cmd(FN_MOVE, 8'd20);
    queue_cmd(FN_TURN_L, 8'd0);
    queue_cmd(FN_MOVE, 8'd5);
    queue_cmd(FN_SPARE_A, 8'hFF);
    queue_cmd(FN_SPARE_B, 8'h00);
    queue_cmd(FN_TURN_L, 8'd0);
    queue_cmd(FN_TURN_L, 8'd0);
    queue_cmd(FN_MOVE, 8'd2);
    queue_cmd(FN_PRINT, 8'd0);

    // random walks that stay on the grid
    repeat (RAND_CMDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)
        queue_cmd(FN_MOVE, 8'($urandom_range(0, room_ahead())));
      else if (pick < 50)
        queue_cmd(FN_PEN_UP, 8'($urandom_range(0, 255)));
      else if (pick < 65)
        queue_cmd(FN_PEN_DOWN, 8'($urandom_range(0, 255)));
      else if (pick < 77)
        queue_cmd(FN_TURN_R, 8'($urandom_range(0, 255)));
      else if (pick < 89)
        queue_cmd(FN_TURN_L, 8'($urandom_range(0, 255)));
      else if (pick < 95)
        queue_cmd(FN_PRINT, 8'($urandom_range(0, 255)));
      else
        queue_cmd(3'($urandom_range(6, 7)), 8'($urandom_range(0, 255)));
    end

    // leave the grid, then everything reports halted
    queue_cmd(FN_MOVE, 8'($urandom_range(room_ahead() + 1, 255)));
    queue_cmd(FN_PRINT, 8'd0);
    queue_cmd(FN_MOVE, 8'd1);
    repeat (10) queue_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // poll on the clock so that queue changes are always seen
    while (cmd_queue.size() != 0 || start) @(posedge clk);
    while (predicted_res.size() != 0) @(posedge clk);
    repeat (3 * SIDE) @(posedge clk);

    if (mismatches == 0) begin
      $display("turtle_grid_plotter_top test passed");
    end else begin
      $display("turtle_grid_plotter_top test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("turtle_grid_plotter_top test failed");
    $finish;
  end

endmodule
